FILE: rtl/assert_macros.svh
// Assertion macros used by the RTL top level.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, ck, rn, cond) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (cond)) \
    else $error("invariant violated");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("implication violated");

`else

`define ASSERT_ALWAYS(lbl, ck, rn, cond)
`define ASSERT_IMPLY(lbl, ck, rn, ante, cons)

`endif

`endif

FILE: rtl/mcma_pkg.sv
// Shared types and fixed constants of the multi-channel moving average.
// No dependencies.
package mcma_pkg;

  localparam int SAMPLE_W = 16;  // sample and average width
  localparam int CHAN_W   = 6;   // channel selector width
  localparam int FIFO_D   = 8;   // result buffer depth
  localparam int FIFO_AW  = 3;   // log2 of FIFO_D

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] average;
    logic                       bad_channel;
  } result_t;

endpackage

FILE: rtl/multi_channel_moving_average.sv
// Multi-channel moving average, top level.
// Depends on mcma_pkg and assert_macros.svh.
//
// Bank of CHANNELS boxcar averages over the last WINDOW samples of each
// channel. in_tuser selects the channel, in_tdata carries a signed sample;
// each input transaction gives exactly one output transaction, in order,
// holding the channel's window sum divided by WINDOW (truncated toward zero)
// in out_tdata. A channel at or above CHANNELS leaves all state untouched and
// returns zero with out_tuser set. One transaction is accepted every clock
// cycle while in_tready is high; the result passes the s1..s4 registers
// and the buffer write before out_tvalid rises. The rate is set by a
// single read-modify-write per item on two memories: a per-channel state
// memory (pointer, wrap flag, running sum) and a sample memory of
// CHANNELS*WINDOW words, both with registered reads; back-to-back items on
// the same channel are handled by forwarding. Results drain through an
// 8-entry buffer with credit flow control, so in_tready drops only when 8
// transactions are accepted and not yet taken at the output. State is ready
// right after reset: per-channel valid flags mark never-used channels, and a
// per-channel wrap flag marks window slots that were never written, so no
// memory clearing pass is needed.
`include "assert_macros.svh"

module multi_channel_moving_average #(
  parameter int CHANNELS = 10,   // 1..64
  parameter int WINDOW   = 5     // 1..64
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample (signed)
  input  logic [5:0]  in_tuser,   // [5:0] channel
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] average (signed)
  output logic [0:0]  out_tuser   // [0] bad_channel
);

  localparam int SW       = mcma_pkg::SAMPLE_W;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PTR_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int DEPTH    = CHANNELS * WINDOW;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LOG_W    = $clog2(WINDOW);
  localparam int SUM_W    = SW + LOG_W;          // holds WINDOW * sample
  localparam int SHIFT    = SUM_W + LOG_W;       // reciprocal scaling
  localparam int RECIP_W  = SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
  localparam int PROD_W   = SUM_W + RECIP_W;
  localparam int Q_W      = SW + 1;
  localparam int CRED_W   = mcma_pkg::FIFO_AW + 1;

  typedef struct packed {
    logic                    wrapped;  // every slot written at least once
    logic [PTR_W-1:0]        ptr;      // next slot to write
    logic signed [SUM_W-1:0] sum;      // window sum
  } chan_state_t;

  // ---------------------------------------------------------------------
  // Storage
  // ---------------------------------------------------------------------
  chan_state_t           chan_mem [CHANNELS];
  logic signed [SW-1:0]  smp_mem  [DEPTH];
  logic [CHANNELS-1:0]   chan_vld_r;         // channel has been written

  // ---------------------------------------------------------------------
  // Stage 0: accept, read channel state
  // ---------------------------------------------------------------------
  logic                in_accept;
  logic                in_bad;
  logic [CH_IDX_W-1:0] in_idx;

  assign in_accept = in_tvalid && in_tready;
  assign in_bad    = {1'b0, in_tuser} >= 7'(CHANNELS);
  assign in_idx    = in_tuser[CH_IDX_W-1:0];

  logic                 s1_vld_r, s1_bad_r, s1_known_r;
  logic [CH_IDX_W-1:0]  s1_idx_r;
  logic signed [SW-1:0] s1_smp_r;
  chan_state_t          chan_q_r;

  always_ff @(posedge clk) begin
    chan_q_r   <= chan_mem[in_idx];
    s1_known_r <= chan_vld_r[in_idx];
    s1_idx_r   <= in_idx;
    s1_smp_r   <= in_tdata;
    s1_bad_r   <= in_bad;
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_accept;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: resolve state with forwarding, advance pointer, read sample
  // ---------------------------------------------------------------------
  logic                 s2_vld_r, s2_bad_r, s2_wrap_old_r, s2_wrap_new_r, s2_fwd_r;
  logic [CH_IDX_W-1:0]  s2_idx_r;
  logic signed [SW-1:0] s2_smp_r, s2_fwd_smp_r, smp_q_r;
  logic [ADDR_W-1:0]    s2_addr_r;
  logic [PTR_W-1:0]     s2_ptr_new_r;
  logic signed [SUM_W-1:0] s2_sum_old_r;

  logic                 s2_wr;
  chan_state_t          s2_state_nxt;
  logic                 wb_vld_r;
  logic [CH_IDX_W-1:0]  wb_idx_r;
  chan_state_t          wb_state_r;

  chan_state_t          s1_cur;
  logic                 s1_last, s1_fwd;
  logic [PTR_W-1:0]     s1_ptr_nxt;
  logic [ADDR_W-1:0]    s1_addr;

  always_comb begin
    // newest copy wins: item in stage 2, then the last write, then memory, else zero for an unused channel
    if (s2_wr && (s2_idx_r == s1_idx_r)) begin
      s1_cur = s2_state_nxt;
    end else if (wb_vld_r && (wb_idx_r == s1_idx_r)) begin
      s1_cur = wb_state_r;
    end else if (s1_known_r) begin
      s1_cur = chan_q_r;
    end else begin
      s1_cur = '0;
    end
    s1_last    = (s1_cur.ptr == PTR_W'(WINDOW - 1));
    s1_ptr_nxt = s1_last ? '0 : s1_cur.ptr + PTR_W'(1);
    s1_addr    = ADDR_W'(s1_idx_r) * ADDR_W'(WINDOW) + ADDR_W'(s1_cur.ptr);
    // same-edge write to the slot being read (single-slot window)
    s1_fwd     = s2_wr && (s2_addr_r == s1_addr);
  end

  always_ff @(posedge clk) begin
    smp_q_r       <= smp_mem[s1_addr];
    s2_bad_r      <= s1_bad_r;
    s2_idx_r      <= s1_idx_r;
    s2_smp_r      <= s1_smp_r;
    s2_addr_r     <= s1_addr;
    s2_wrap_old_r <= s1_cur.wrapped;
    s2_sum_old_r  <= s1_cur.sum;
    s2_ptr_new_r  <= s1_ptr_nxt;
    s2_wrap_new_r <= s1_cur.wrapped | s1_last;
    s2_fwd_r      <= s1_fwd;
    s2_fwd_smp_r  <= s2_smp_r;
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: update running sum, write back both memories
  // ---------------------------------------------------------------------
  logic signed [SW-1:0]    s2_old;
  logic signed [SUM_W-1:0] s2_sum_nxt;
  logic [SUM_W-1:0]        s2_mag;

  always_comb begin
    if (!s2_wrap_old_r) begin
      s2_old = '0;             // slot never written
    end else if (s2_fwd_r) begin
      s2_old = s2_fwd_smp_r;
    end else begin
      s2_old = smp_q_r;
    end
    s2_sum_nxt   = s2_sum_old_r + SUM_W'(s2_smp_r) - SUM_W'(s2_old);
    s2_wr        = s2_vld_r && !s2_bad_r;
    s2_state_nxt = '{wrapped: s2_wrap_new_r, ptr: s2_ptr_new_r, sum: s2_sum_nxt};
    s2_mag       = s2_sum_nxt[SUM_W-1] ? SUM_W'(-s2_sum_nxt) : SUM_W'(s2_sum_nxt);
  end

  always_ff @(posedge clk) begin
    if (s2_wr) begin
      chan_mem[s2_idx_r] <= s2_state_nxt;
      smp_mem[s2_addr_r] <= s2_smp_r;
    end
  end

  always_ff @(posedge clk) begin
    wb_idx_r   <= s2_idx_r;
    wb_state_r <= s2_state_nxt;
    if (!rst_n) begin
      chan_vld_r <= '0;
      wb_vld_r   <= 1'b0;
    end else begin
      wb_vld_r <= s2_wr;
      if (s2_wr) begin
        chan_vld_r[s2_idx_r] <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stages 3-4: magnitude times reciprocal of WINDOW, restore sign
  // ---------------------------------------------------------------------
  logic                 s3_vld_r, s3_bad_r, s3_neg_r;
  logic [SUM_W-1:0]     s3_mag_r;
  logic                 s4_vld_r, s4_bad_r, s4_neg_r;
  logic [Q_W-1:0]       s4_q_r;
  logic [PROD_W-1:0]    s3_prod;

  assign s3_prod = PROD_W'(s3_mag_r) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    s3_bad_r <= s2_bad_r;
    s3_neg_r <= s2_sum_nxt[SUM_W-1];
    s3_mag_r <= s2_mag;
    s4_bad_r <= s3_bad_r;
    s4_neg_r <= s3_neg_r;
    s4_q_r   <= Q_W'(s3_prod >> SHIFT);
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  mcma_pkg::result_t s4_res;
  logic [Q_W-1:0]    s4_signed_q;

  always_comb begin
    s4_signed_q        = s4_neg_r ? -s4_q_r : s4_q_r;
    s4_res.average     = s4_bad_r ? '0 : SW'(s4_signed_q);
    s4_res.bad_channel = s4_bad_r;
  end

  // ---------------------------------------------------------------------
  // Result buffer with credit count
  // ---------------------------------------------------------------------
  mcma_pkg::result_t               fifo_mem [mcma_pkg::FIFO_D];
  logic [mcma_pkg::FIFO_AW:0]      wr_ptr_r, rd_ptr_r;
  logic [CRED_W-1:0]               cred_r, cred_nxt;
  logic                            out_pop;
  mcma_pkg::result_t               head;

  assign out_pop   = out_tvalid && out_tready;
  assign in_tready = cred_r < CRED_W'(mcma_pkg::FIFO_D);
  assign cred_nxt  = cred_r + CRED_W'(in_accept) - CRED_W'(out_pop);

  always_ff @(posedge clk) begin
    if (s4_vld_r) begin
      fifo_mem[wr_ptr_r[mcma_pkg::FIFO_AW-1:0]] <= s4_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cred_r   <= '0;
    end else begin
      cred_r <= cred_nxt;
      if (s4_vld_r) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (out_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  assign head       = fifo_mem[rd_ptr_r[mcma_pkg::FIFO_AW-1:0]];
  assign out_tvalid = (wr_ptr_r != rd_ptr_r);
  assign out_tdata  = head.average;
  assign out_tuser  = head.bad_channel;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `ASSERT_ALWAYS(a_credit_bound, clk, rst_n, cred_r <= CRED_W'(mcma_pkg::FIFO_D))
  `ASSERT_ALWAYS(a_fifo_within_credit, clk, rst_n, (wr_ptr_r - rd_ptr_r) <= cred_r)
  `ASSERT_IMPLY(a_ptr_in_window, clk, rst_n, s2_wr, int'(s2_ptr_new_r) < WINDOW)
  `ASSERT_IMPLY(a_bad_is_zero, clk, rst_n, out_tvalid && out_tuser[0], out_tdata == '0)

endmodule
